@@ rtl/assert_macros.svh @@
// Assertion macros for the score update block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("implication check failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("next-cycle check failed");
`endif

@@ rtl/chb_pkg.sv @@
// Shared types and constants of the score update block.
// No dependencies.
package chb_pkg;

    localparam logic [1:0] CFG_INIT_LR = 2'd0;
    localparam logic [1:0] CFG_MIN_LR  = 2'd1;
    localparam logic [1:0] CFG_LR_STEP = 2'd2;
    localparam logic [1:0] CFG_NC_MULT = 2'd3;

    localparam logic [31:0] RST_INIT_LR = 32'd1717986918;
    localparam logic [31:0] RST_MIN_LR  = 32'd257698038;
    localparam logic [15:0] RST_LR_STEP = 16'd4295;
    localparam logic [32:0] RST_NC_MULT = 33'd3865470566;
    localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;

    localparam logic KIND_BUMP = 1'b0;
    localparam logic KIND_MARK = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [9:0]  idx;
        logic        conflict;
        logic        last;
        logic [31:0] count;
    } t_item;

    typedef struct packed {
        logic [31:0] min_lr;
        logic [15:0] lr_step;
        logic [32:0] nc_mult;
        logic        lr_load;
        logic [31:0] lr_load_val;
    } t_cfg;

    typedef struct packed {
        logic clearing;
        logic pop;
    } t_back_stat;

endpackage

@@ rtl/chb_front.sv @@
// Front end: accepts items, drops those with no effect, hands the rest on.
// Depends on chb_pkg.
module chb_front #(
    parameter int NUM_VARS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_kind,
    input  logic [9:0]    i_var_index,
    input  logic          i_conflict,
    input  logic          i_last,
    input  logic [31:0]   i_conflict_count,
    input  logic          i_active,
    input  logic          i_q_full,
    output logic          o_push,
    output chb_pkg::t_item o_item
);
    import chb_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item;
    logic  accept, keep;

    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    // out-of-range index or inactive mark: no effect at all
    assign keep    = (32'(i_var_index) < NUM_VARS) && (i_kind == KIND_BUMP || i_active);
    assign o_push  = r_valid && !i_q_full;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid = keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_item <= '{kind: i_kind, idx: i_var_index, conflict: i_conflict,
                        last: i_last, count: i_conflict_count};
        end
    end
endmodule

@@ rtl/chb_fifo.sv @@
// Two-entry item queue between front and back.
// Depends on chb_pkg.
module chb_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  chb_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output chb_pkg::t_item o_item
);
    import chb_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

@@ rtl/chb_back.sv @@
// Back end: tables, clearing pass, radix-2 divider, blend and result register.
// Depends on chb_pkg.
module chb_back #(
    parameter int NUM_VARS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  chb_pkg::t_item     i_q_item,
    input  chb_pkg::t_cfg      i_cfg,
    output chb_pkg::t_back_stat o_stat,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [9:0]         o_bumped_var,
    output logic [31:0]        o_new_score
);
    import chb_pkg::*;

    localparam int IDX_W = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MA    = 3'd4;
    localparam logic [2:0] S_MB    = 3'd5;
    localparam logic [2:0] S_SUM   = 3'd6;

    logic [31:0] r_score_mem [NUM_VARS];
    logic [31:0] r_last_mem  [NUM_VARS];

    logic [2:0]       r_state;
    logic [IDX_W-1:0] r_clr;
    logic [5:0]       r_cnt;
    t_item            r_item;
    logic [31:0]      r_rd_score, r_rd_last, r_old;
    logic [32:0]      r_num;   // numerator, shifted out as quotient comes in
    logic [32:0]      r_den;
    logic [32:0]      r_rem;
    logic [63:0]      r_prod;
    logic [64:0]      r_acc;
    logic             r_rh;
    logic [31:0]      r_lr;
    logic             r_ov;
    logic [9:0]       r_ovar;
    logic [31:0]      r_oscore;

    logic             pop, commit;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [33:0]      rem_sh;
    logic             q_bit;
    logic [33:0]      sum;
    logic [31:0]      score;

    assign pop     = (r_state == S_IDLE) && i_q_valid;
    assign rd_addr = IDX_W'(i_q_item.idx);
    assign wr_addr = IDX_W'(r_item.idx);
    assign commit  = (r_state == S_SUM) && (!r_ov || !i_stall);

    assign rem_sh = {r_rem, r_num[32]};
    assign q_bit  = (rem_sh >= {1'b0, r_den});

    assign sum   = {1'b0, r_acc[64:32]} + (r_rh ? {2'b0, r_lr} : 34'd0);
    assign score = (sum > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];

    assign o_stat       = '{clearing: (r_state == S_CLEAR), pop: pop};
    assign o_valid      = r_ov;
    assign o_bumped_var = r_ovar;
    assign o_new_score  = r_oscore;

    // table ports
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rd_score <= r_score_mem[rd_addr];
            r_rd_last  <= r_last_mem[rd_addr];
        end
        if (r_state == S_CLEAR) begin
            r_score_mem[r_clr] <= 32'd0;
            r_last_mem[r_clr]  <= 32'd0;
        end else if (r_state == S_READ && r_item.kind == KIND_MARK) begin
            r_last_mem[wr_addr] <= r_item.count;
        end else if (commit) begin
            r_score_mem[wr_addr] <= score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_lr    <= RST_INIT_LR;
        end else begin
            if (r_ov && !i_stall && !commit) begin
                r_ov <= 1'b0;
            end
            if (i_cfg.lr_load) begin
                r_lr <= i_cfg.lr_load_val;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IDX_W'(NUM_VARS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (pop) begin
                        r_item  <= i_q_item;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_item.kind == KIND_MARK) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_old   <= r_rd_score;
                        r_rem   <= 33'd0;
                        r_num   <= r_item.conflict ? ONE_Q32 : i_cfg.nc_mult;
                        r_den   <= {1'b0, r_item.count - r_rd_last} + 33'd1;
                        r_cnt   <= 6'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= q_bit ? 33'(rem_sh - {1'b0, r_den}) : rem_sh[32:0];
                    r_num <= {r_num[31:0], q_bit};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd32) begin
                        r_state <= S_MA;
                    end
                end
                S_MA: begin
                    r_prod  <= r_lr * r_num[31:0];
                    r_rh    <= r_num[32];
                    r_state <= S_MB;
                end
                S_MB: begin
                    // (1 - lr) * old as old*2^32 - lr*old
                    r_acc   <= {1'b0, r_prod} + {1'b0, {r_old, 32'd0} - r_lr * r_old};
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (commit) begin
                        r_ov     <= 1'b1;
                        r_ovar   <= r_item.idx;
                        r_oscore <= score;
                        if (r_item.last && r_item.conflict && r_lr > i_cfg.min_lr) begin
                            r_lr <= (r_lr > {16'd0, i_cfg.lr_step})
                                  ? r_lr - {16'd0, i_cfg.lr_step} : 32'd0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/chb_score_update.sv @@
// Top level of the conflict-history branching score unit.
// Depends on chb_pkg, chb_front, chb_fifo, chb_back and assert_macros.svh.

// Keeps a Q0.32 score and a last-conflict stamp per variable plus a decaying
// learning rate. A bump item returns one result (variable, new score); a mark
// item returns none and stamps the conflict count for an active variable.
// After reset the tables are zeroed by a clearing pass over all NUM_VARS
// entries, during which no item is processed (config writes still land). A
// bump passes through the pop/table read, a set-up step, 33 steps of the
// radix-2 restoring divider that forms the reward, the multiply states S_MA
// and S_MB and the blend/write in the back end; a mark passes only through the
// read and set-up. The front end and a two-item queue keep accepting while the back end works, until the queue is full.
module chb_score_update #(
    parameter int NUM_VARS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [32:0] i_cfg_data,
    // item input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [9:0]  i_var_index,
    input  logic        i_conflict,
    input  logic        i_last,
    input  logic [31:0] i_conflict_count,
    input  logic        i_active,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [9:0]  o_bumped_var,
    output logic [31:0] o_new_score
);
    import chb_pkg::*;

    `include "assert_macros.svh"

    logic [31:0] r_min_lr;
    logic [15:0] r_lr_step;
    logic [32:0] r_nc_mult;
    t_cfg        cfg;

    logic       push, q_full, q_valid;
    t_item      f_item, q_item;
    t_back_stat bstat;

    // config registers; writing the initial rate also reloads the live rate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_lr  <= RST_MIN_LR;
            r_lr_step <= RST_LR_STEP;
            r_nc_mult <= RST_NC_MULT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INIT_LR: ;
                CFG_MIN_LR:  r_min_lr  <= i_cfg_data[31:0];
                CFG_LR_STEP: r_lr_step <= i_cfg_data[15:0];
                CFG_NC_MULT: r_nc_mult <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = '{min_lr: r_min_lr, lr_step: r_lr_step, nc_mult: r_nc_mult,
                   lr_load: i_cfg_we && (i_cfg_idx == CFG_INIT_LR),
                   lr_load_val: i_cfg_data[31:0]};

    chb_front #(.NUM_VARS(NUM_VARS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_kind, .i_var_index, .i_conflict, .i_last, .i_conflict_count, .i_active,
        .i_q_full(q_full), .o_push(push), .o_item(f_item)
    );

    chb_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push(push), .i_item(f_item), .o_full(q_full),
        .i_pop(bstat.pop), .o_valid(q_valid), .o_item(q_item)
    );

    chb_back #(.NUM_VARS(NUM_VARS)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .i_q_item(q_item), .i_cfg(cfg), .o_stat(bstat),
        .o_valid, .i_stall, .o_bumped_var, .o_new_score
    );

    // queue never written when full, never read while tables are being cleared
    `ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, push, !q_full)
    `ASSERT_IMPL(a_no_pop_clear, i_clk, i_rst_n, bstat.clearing, !bstat.pop)
    // a pop only happens when the queue holds an item
    `ASSERT_IMPL(a_pop_has_item, i_clk, i_rst_n, bstat.pop, q_valid)

endmodule
